// File: rtl/core/sht_pkg.sv
// shared types, register map, codes and constants of the two-wire sequencer
package sht_pkg;

  // configuration register map
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;
  localparam int CFG_TICK_W  = 16;
  localparam int CFG_POLL_W  = 10;

  localparam logic [CFG_INDEX_W-1:0] CFG_CLOCK_HOLD   = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_DATA_SETUP   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] CFG_POLL_INTVL   = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] CFG_ACK_LIMIT    = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] CFG_SETTLE_POLLS = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] CFG_READY_LIMIT  = 3'd5;

  localparam logic [CFG_TICK_W-1:0] RST_CLOCK_HOLD   = 16'd100;
  localparam logic [CFG_TICK_W-1:0] RST_DATA_SETUP   = 16'd150;
  localparam logic [CFG_TICK_W-1:0] RST_POLL_INTVL   = 16'd1000;
  localparam logic [CFG_POLL_W-1:0] RST_ACK_LIMIT    = 10'd100;
  localparam logic [CFG_POLL_W-1:0] RST_SETTLE_POLLS = 10'd300;
  localparam logic [CFG_POLL_W-1:0] RST_READY_LIMIT  = 10'd500;

  // default counter widths
  localparam int DEF_TICK_COUNT_WIDTH = 16;
  localparam int DEF_POLL_COUNT_WIDTH = 10;

  // request kinds
  localparam logic [1:0] REQ_TEMP   = 2'd0;
  localparam logic [1:0] REQ_HUMID  = 2'd1;
  localparam logic [1:0] REQ_STATUS = 2'd2;
  localparam logic [1:0] REQ_NONE   = 2'd3;

  // error codes
  localparam logic [1:0] ERR_NONE      = 2'd0;
  localparam logic [1:0] ERR_NO_ACK    = 2'd1;
  localparam logic [1:0] ERR_NOT_READY = 2'd2;

  localparam logic [7:0] CMD_TEMP   = 8'h03;
  localparam logic [7:0] CMD_HUMID  = 8'h05;
  localparam logic [7:0] CMD_STATUS = 8'h07;

  // one request: one timing tick with the sampled data line
  typedef struct packed {
    logic       req_valid;
    logic [1:0] req_type;
    logic       sda_in;
  } tick_req_t;

  // line levels and transaction status after one tick
  typedef struct packed {
    logic        scl_out;
    logic        sda_out;
    logic        sda_drive;
    logic        busy_res;
    logic        done_res;
    logic [1:0]  error_code;
    logic [15:0] read_value;
  } seq_result_t;

  function automatic logic [7:0] cmd_byte(input logic [1:0] kind);
    logic [7:0] cmd;
    cmd = CMD_STATUS;
    case (kind)
      REQ_TEMP:   cmd = CMD_TEMP;
      REQ_HUMID:  cmd = CMD_HUMID;
      REQ_STATUS: cmd = CMD_STATUS;
      default:    cmd = CMD_STATUS;
    endcase
    return cmd;
  endfunction

endpackage

// File: rtl/core/sht1x_two_wire_transaction_sequencer.sv
// top level of the two-wire sensor transaction sequencer
// Each request on the input channel is one timing tick carrying a start strobe
// (in_req_valid), the request kind (in_req_type: temperature, humidity or
// status) and the sampled data line (in_sda_in). Each tick yields exactly one
// result with the clock line level, data line level and drive enable, a busy
// flag and, on the tick that ends a transaction, a done pulse with the error
// code and value read. One tick is taken per clock cycle as long as out_ready
// is high: a request is held in the input register, the state machine steps on
// it and its result lands in the output register, and the next request enters
// the input register as the buffered one steps. Transaction length in ticks is
// set by the hold, setup and poll registers, not by the clock. Configuration
// writes (cfg_index 0..5) are always taken and should only be issued while idle.
module sht1x_two_wire_transaction_sequencer #(
  parameter int TICK_COUNT_WIDTH = sht_pkg::DEF_TICK_COUNT_WIDTH,
  parameter int POLL_COUNT_WIDTH = sht_pkg::DEF_POLL_COUNT_WIDTH
) (
  input  logic                             clk,
  input  logic                             rst_n,
  // tick requests
  input  logic                             in_valid,
  output logic                             in_ready,
  input  logic                             in_req_valid,
  input  logic [1:0]                       in_req_type,
  input  logic                             in_sda_in,
  // per-tick results
  output logic                             out_valid,
  input  logic                             out_ready,
  output logic                             out_scl_out,
  output logic                             out_sda_out,
  output logic                             out_sda_drive,
  output logic                             out_busy_res,
  output logic                             out_done_res,
  output logic [1:0]                       out_error_code,
  output logic [15:0]                      out_read_value,
  // configuration writes
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [sht_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [sht_pkg::CFG_DATA_W-1:0]   cfg_data
);
  import sht_pkg::*;

  tick_req_t                   in_req, req_q;
  logic                        req_q_valid;
  logic                        out_space;
  logic                        step;
  seq_result_t                 res_d, res_q;
  logic [TICK_COUNT_WIDTH-1:0] clock_hold, data_setup, poll_intvl;
  logic [CFG_POLL_W-1:0]       ack_limit, settle_polls, ready_limit;

  // register writes never stall
  assign cfg_ready = 1'b1;

  assign in_req.req_valid = in_req_valid;
  assign in_req.req_type  = in_req_type;
  assign in_req.sda_in    = in_sda_in;

  // the state machine steps once per buffered tick that has room downstream
  assign step = req_q_valid && out_space;

  sht_cfg_regs #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH)
  ) u_cfg (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en_i        (cfg_valid && cfg_ready),
    .wr_index_i     (cfg_index),
    .wr_data_i      (cfg_data),
    .clock_hold_o   (clock_hold),
    .data_setup_o   (data_setup),
    .poll_intvl_o   (poll_intvl),
    .ack_limit_o    (ack_limit),
    .settle_polls_o (settle_polls),
    .ready_limit_o  (ready_limit)
  );

  sht_in_reg u_in (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_req_i   (in_req),
    .take_i     (step),
    .valid_o    (req_q_valid),
    .req_o      (req_q)
  );

  sht_seq_core #(
    .TICK_COUNT_WIDTH (TICK_COUNT_WIDTH),
    .POLL_COUNT_WIDTH (POLL_COUNT_WIDTH)
  ) u_core (
    .clk            (clk),
    .rst_n          (rst_n),
    .step_i         (step),
    .req_i          (req_q),
    .clock_hold_i   (clock_hold),
    .data_setup_i   (data_setup),
    .poll_intvl_i   (poll_intvl),
    .ack_limit_i    (ack_limit),
    .settle_polls_i (settle_polls),
    .ready_limit_i  (ready_limit),
    .res_o          (res_d)
  );

  sht_out_reg u_out (
    .clk         (clk),
    .rst_n       (rst_n),
    .load_i      (step),
    .res_i       (res_d),
    .space_o     (out_space),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .res_o       (res_q)
  );

  assign out_scl_out    = res_q.scl_out;
  assign out_sda_out    = res_q.sda_out;
  assign out_sda_drive  = res_q.sda_drive;
  assign out_busy_res   = res_q.busy_res;
  assign out_done_res   = res_q.done_res;
  assign out_error_code = res_q.error_code;
  assign out_read_value = res_q.read_value;

endmodule

// File: rtl/core/sht_cfg_regs.sv
// configuration registers with tick values saturated to the counter width
module sht_cfg_regs #(
  parameter int TICK_COUNT_WIDTH = sht_pkg::DEF_TICK_COUNT_WIDTH
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                wr_en_i,
  input  logic [sht_pkg::CFG_INDEX_W-1:0]     wr_index_i,
  input  logic [sht_pkg::CFG_DATA_W-1:0]      wr_data_i,
  output logic [TICK_COUNT_WIDTH-1:0]         clock_hold_o,
  output logic [TICK_COUNT_WIDTH-1:0]         data_setup_o,
  output logic [TICK_COUNT_WIDTH-1:0]         poll_intvl_o,
  output logic [sht_pkg::CFG_POLL_W-1:0]      ack_limit_o,
  output logic [sht_pkg::CFG_POLL_W-1:0]      settle_polls_o,
  output logic [sht_pkg::CFG_POLL_W-1:0]      ready_limit_o
);
  import sht_pkg::*;

  logic [CFG_TICK_W-1:0] clock_hold_r, data_setup_r, poll_intvl_r;
  logic [CFG_POLL_W-1:0] ack_limit_r, settle_polls_r, ready_limit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clock_hold_r   <= RST_CLOCK_HOLD;
      data_setup_r   <= RST_DATA_SETUP;
      poll_intvl_r   <= RST_POLL_INTVL;
      ack_limit_r    <= RST_ACK_LIMIT;
      settle_polls_r <= RST_SETTLE_POLLS;
      ready_limit_r  <= RST_READY_LIMIT;
    end else if (wr_en_i) begin
      case (wr_index_i)
        CFG_CLOCK_HOLD:   clock_hold_r   <= wr_data_i;
        CFG_DATA_SETUP:   data_setup_r   <= wr_data_i;
        CFG_POLL_INTVL:   poll_intvl_r   <= wr_data_i;
        CFG_ACK_LIMIT:    ack_limit_r    <= wr_data_i[CFG_POLL_W-1:0];
        CFG_SETTLE_POLLS: settle_polls_r <= wr_data_i[CFG_POLL_W-1:0];
        CFG_READY_LIMIT:  ready_limit_r  <= wr_data_i[CFG_POLL_W-1:0];
        default: ;
      endcase
    end
  end

  assign ack_limit_o    = ack_limit_r;
  assign settle_polls_o = settle_polls_r;
  assign ready_limit_o  = ready_limit_r;

  // tick values above the tick counter range clamp to its maximum
  if (TICK_COUNT_WIDTH >= CFG_TICK_W) begin : g_wide
    assign clock_hold_o = TICK_COUNT_WIDTH'(clock_hold_r);
    assign data_setup_o = TICK_COUNT_WIDTH'(data_setup_r);
    assign poll_intvl_o = TICK_COUNT_WIDTH'(poll_intvl_r);
  end else begin : g_sat
    assign clock_hold_o = (|clock_hold_r[CFG_TICK_W-1:TICK_COUNT_WIDTH]) ? '1
                        : clock_hold_r[TICK_COUNT_WIDTH-1:0];
    assign data_setup_o = (|data_setup_r[CFG_TICK_W-1:TICK_COUNT_WIDTH]) ? '1
                        : data_setup_r[TICK_COUNT_WIDTH-1:0];
    assign poll_intvl_o = (|poll_intvl_r[CFG_TICK_W-1:TICK_COUNT_WIDTH]) ? '1
                        : poll_intvl_r[TICK_COUNT_WIDTH-1:0];
  end

endmodule

// File: rtl/core/sht_in_reg.sv
// input register for tick requests
module sht_in_reg (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  sht_pkg::tick_req_t in_req_i,
  input  logic               take_i,
  output logic               valid_o,
  output sht_pkg::tick_req_t req_o
);
  import sht_pkg::*;

  logic      valid_r, valid_nxt;
  tick_req_t req_r;
  logic      load;

  assign in_ready_o = !valid_r || take_i;
  assign load       = in_valid_i && in_ready_o;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (take_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      req_r <= in_req_i;
    end
  end

  assign valid_o = valid_r;
  assign req_o   = req_r;

endmodule

// File: rtl/core/sht_seq_core.sv
// transaction state machine, advanced by one tick per step
module sht_seq_core #(
  parameter int TICK_COUNT_WIDTH = sht_pkg::DEF_TICK_COUNT_WIDTH,
  parameter int POLL_COUNT_WIDTH = sht_pkg::DEF_POLL_COUNT_WIDTH
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            step_i,
  input  sht_pkg::tick_req_t              req_i,
  input  logic [TICK_COUNT_WIDTH-1:0]     clock_hold_i,
  input  logic [TICK_COUNT_WIDTH-1:0]     data_setup_i,
  input  logic [TICK_COUNT_WIDTH-1:0]     poll_intvl_i,
  input  logic [sht_pkg::CFG_POLL_W-1:0]  ack_limit_i,
  input  logic [sht_pkg::CFG_POLL_W-1:0]  settle_polls_i,
  input  logic [sht_pkg::CFG_POLL_W-1:0]  ready_limit_i,
  output sht_pkg::seq_result_t            res_o
);
  import sht_pkg::*;

  localparam int CMP_W = (POLL_COUNT_WIDTH > CFG_POLL_W) ? POLL_COUNT_WIDTH : CFG_POLL_W;
  localparam logic [POLL_COUNT_WIDTH-1:0] POLL_MAX = '1;
  localparam logic [4:0] CMD_BITS   = 5'd8;
  localparam logic [4:0] RESET_PULS = 5'd9;
  localparam logic [4:0] BYTE_BITS  = 5'd8;
  localparam logic [4:0] WORD_BITS  = 5'd16;

  typedef enum logic [30:0] {
    PH_IDLE     = 31'h00000001,
    PH_S1       = 31'h00000002,
    PH_S2       = 31'h00000004,
    PH_S3       = 31'h00000008,
    PH_S4       = 31'h00000010,
    PH_S5       = 31'h00000020,
    PH_S6       = 31'h00000040,
    PH_S7       = 31'h00000080,
    PH_TX_D     = 31'h00000100,
    PH_TX_H     = 31'h00000200,
    PH_TX_L     = 31'h00000400,
    PH_ACK_REL  = 31'h00000800,
    PH_ACK_WAIT = 31'h00001000,
    PH_CR_LO    = 31'h00002000,
    PH_CR_H     = 31'h00004000,
    PH_CR_L     = 31'h00008000,
    PH_XH       = 31'h00010000,
    PH_XL       = 31'h00020000,
    PH_MEAS     = 31'h00040000,
    PH_SETTLE   = 31'h00080000,
    PH_READY    = 31'h00100000,
    PH_RD_H     = 31'h00200000,
    PH_RD_L     = 31'h00400000,
    PH_AK_D     = 31'h00800000,
    PH_AK_H     = 31'h01000000,
    PH_AK_L     = 31'h02000000,
    PH_AK_R     = 31'h04000000,
    PH_EN_D     = 31'h08000000,
    PH_EN_H     = 31'h10000000,
    PH_EN_L     = 31'h20000000,
    PH_FIN      = 31'h40000000
  } phase_t;

  phase_t                      phase_r, phase_nxt;
  logic [TICK_COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [POLL_COUNT_WIDTH-1:0] poll_r, poll_nxt;
  logic [4:0]                  bit_r, bit_nxt;
  logic [15:0]                 shift_r, shift_nxt;
  logic [1:0]                  kind_r, kind_nxt;
  logic                        scl_r, scl_nxt;
  logic                        sda_r, sda_nxt;
  logic                        drive_r, drive_nxt;
  logic [1:0]                  err_r, err_nxt;

  logic [POLL_COUNT_WIDTH-1:0] poll_inc;
  logic                        ack_fail, ready_fail, settle_done;
  logic [4:0]                  bit_inc;
  logic                        done;
  logic [15:0]                 value;

  // saturating poll count and limit checks
  assign poll_inc    = (poll_r == POLL_MAX) ? poll_r : poll_r + 1'b1;
  assign ack_fail    = (CMP_W'(poll_inc) >= CMP_W'(ack_limit_i)) || (poll_inc == POLL_MAX);
  assign ready_fail  = (CMP_W'(poll_inc) >= CMP_W'(ready_limit_i)) || (poll_inc == POLL_MAX);
  assign settle_done = (CMP_W'(poll_r) >= CMP_W'(settle_polls_i)) || (poll_r == POLL_MAX);
  assign bit_inc     = bit_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    tick_nxt  = tick_r;
    poll_nxt  = poll_r;
    bit_nxt   = bit_r;
    shift_nxt = shift_r;
    kind_nxt  = kind_r;
    scl_nxt   = scl_r;
    sda_nxt   = sda_r;
    drive_nxt = drive_r;
    err_nxt   = err_r;
    done      = 1'b0;
    value     = '0;
    if (phase_r == PH_IDLE) begin
      if (req_i.req_valid && (req_i.req_type != REQ_NONE)) begin
        kind_nxt  = req_i.req_type;
        shift_nxt = {8'h00, cmd_byte(req_i.req_type)};
        err_nxt   = ERR_NONE;
        drive_nxt = 1'b1;
        sda_nxt   = 1'b1;
        tick_nxt  = data_setup_i;
        phase_nxt = PH_S1;
      end
    end else if (tick_r != '0) begin
      tick_nxt = tick_r - 1'b1;
    end else begin
      case (phase_r)
        // transmission start: data falls and rises while clock is high
        PH_S1: begin scl_nxt = 1'b0; tick_nxt = clock_hold_i; phase_nxt = PH_S2; end
        PH_S2: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_S3; end
        PH_S3: begin
          drive_nxt = 1'b1; sda_nxt = 1'b0; tick_nxt = data_setup_i; phase_nxt = PH_S4;
        end
        PH_S4: begin scl_nxt = 1'b0; tick_nxt = clock_hold_i; phase_nxt = PH_S5; end
        PH_S5: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_S6; end
        PH_S6: begin
          drive_nxt = 1'b1; sda_nxt = 1'b1; tick_nxt = data_setup_i; phase_nxt = PH_S7;
        end
        PH_S7: begin
          bit_nxt = '0; scl_nxt = 1'b0; tick_nxt = clock_hold_i; phase_nxt = PH_TX_D;
        end
        // command byte, msb first
        PH_TX_D: begin
          drive_nxt = 1'b1; sda_nxt = shift_r[7]; tick_nxt = data_setup_i;
          phase_nxt = PH_TX_H;
        end
        PH_TX_H: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_TX_L; end
        PH_TX_L: begin
          shift_nxt = {8'h00, shift_r[6:0], 1'b0};
          bit_nxt   = bit_inc;
          scl_nxt   = 1'b0;
          tick_nxt  = clock_hold_i;
          phase_nxt = (bit_inc >= CMD_BITS) ? PH_ACK_REL : PH_TX_D;
        end
        PH_ACK_REL: begin
          drive_nxt = 1'b0; poll_nxt = '0; tick_nxt = poll_intvl_i; phase_nxt = PH_ACK_WAIT;
        end
        PH_ACK_WAIT: begin
          if (!req_i.sda_in) begin
            scl_nxt = 1'b0; tick_nxt = clock_hold_i; phase_nxt = PH_XH;
          end else begin
            poll_nxt = poll_inc;
            if (ack_fail) begin
              err_nxt   = ERR_NO_ACK;
              drive_nxt = 1'b1;
              sda_nxt   = 1'b1;
              scl_nxt   = 1'b0;
              tick_nxt  = clock_hold_i;
              phase_nxt = PH_CR_LO;
            end else begin
              tick_nxt = poll_intvl_i;
            end
          end
        end
        // connection reset: RESET_PULS clock pulses with data high
        PH_CR_LO: begin
          bit_nxt = '0; scl_nxt = 1'b0; tick_nxt = clock_hold_i; phase_nxt = PH_CR_H;
        end
        PH_CR_H: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_CR_L; end
        PH_CR_L: begin
          bit_nxt   = bit_inc;
          scl_nxt   = 1'b0;
          tick_nxt  = clock_hold_i;
          phase_nxt = (bit_inc >= RESET_PULS) ? PH_XH : PH_CR_H;
        end
        // extra clock pulse
        PH_XH: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_XL; end
        PH_XL: begin
          scl_nxt  = 1'b0;
          tick_nxt = clock_hold_i;
          if (err_r != ERR_NONE) begin
            shift_nxt = '0; phase_nxt = PH_FIN;
          end else if (kind_r == REQ_STATUS) begin
            shift_nxt = '0; bit_nxt = '0; drive_nxt = 1'b0; phase_nxt = PH_RD_H;
          end else begin
            phase_nxt = PH_MEAS;
          end
        end
        PH_MEAS: begin
          drive_nxt = 1'b0; scl_nxt = 1'b0; poll_nxt = '0; tick_nxt = '0;
          phase_nxt = PH_SETTLE;
        end
        PH_SETTLE: begin
          if (settle_done) begin
            poll_nxt = '0; phase_nxt = PH_READY;
          end else begin
            poll_nxt = poll_r + 1'b1;
          end
          tick_nxt = poll_intvl_i;
        end
        PH_READY: begin
          if (!req_i.sda_in) begin
            shift_nxt = '0; bit_nxt = '0; phase_nxt = PH_RD_H;
          end else begin
            poll_nxt = poll_inc;
            if (ready_fail) begin
              err_nxt = ERR_NOT_READY; shift_nxt = '0; phase_nxt = PH_FIN;
            end else begin
              tick_nxt = poll_intvl_i;
            end
          end
        end
        // data bits sampled on the clock's falling step
        PH_RD_H: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_RD_L; end
        PH_RD_L: begin
          shift_nxt = {shift_r[14:0], req_i.sda_in};
          bit_nxt   = bit_inc;
          scl_nxt   = 1'b0;
          tick_nxt  = clock_hold_i;
          if (kind_r == REQ_STATUS) begin
            phase_nxt = (bit_inc >= BYTE_BITS) ? PH_FIN : PH_RD_H;
          end else if (bit_inc == BYTE_BITS) begin
            phase_nxt = PH_AK_D;
          end else begin
            phase_nxt = (bit_inc >= WORD_BITS) ? PH_EN_D : PH_RD_H;
          end
        end
        // acknowledge after the first byte
        PH_AK_D: begin
          drive_nxt = 1'b1; sda_nxt = 1'b0; tick_nxt = data_setup_i; phase_nxt = PH_AK_H;
        end
        PH_AK_H: begin scl_nxt = 1'b1; tick_nxt = data_setup_i; phase_nxt = PH_AK_L; end
        PH_AK_L: begin scl_nxt = 1'b0; tick_nxt = data_setup_i; phase_nxt = PH_AK_R; end
        PH_AK_R: begin
          sda_nxt = 1'b1; drive_nxt = 1'b0; tick_nxt = '0; phase_nxt = PH_RD_H;
        end
        // closing no-acknowledge
        PH_EN_D: begin
          drive_nxt = 1'b1; sda_nxt = 1'b1; tick_nxt = data_setup_i; phase_nxt = PH_EN_H;
        end
        PH_EN_H: begin scl_nxt = 1'b1; tick_nxt = clock_hold_i; phase_nxt = PH_EN_L; end
        PH_EN_L: begin scl_nxt = 1'b0; tick_nxt = clock_hold_i; phase_nxt = PH_FIN; end
        PH_FIN: begin
          done      = 1'b1;
          value     = (err_r != ERR_NONE) ? 16'h0000 : shift_r;
          phase_nxt = PH_IDLE;
          tick_nxt  = '0;
        end
        default: begin
          phase_nxt = PH_IDLE; tick_nxt = '0;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      tick_r  <= '0;
      poll_r  <= '0;
      bit_r   <= '0;
      shift_r <= '0;
      kind_r  <= REQ_TEMP;
      scl_r   <= 1'b0;
      sda_r   <= 1'b1;
      drive_r <= 1'b0;
      err_r   <= ERR_NONE;
    end else if (step_i) begin
      phase_r <= phase_nxt;
      tick_r  <= tick_nxt;
      poll_r  <= poll_nxt;
      bit_r   <= bit_nxt;
      shift_r <= shift_nxt;
      kind_r  <= kind_nxt;
      scl_r   <= scl_nxt;
      sda_r   <= sda_nxt;
      drive_r <= drive_nxt;
      err_r   <= err_nxt;
    end
  end

  always_comb begin
    res_o.scl_out    = scl_nxt;
    res_o.sda_out    = sda_nxt;
    res_o.sda_drive  = drive_nxt;
    res_o.busy_res   = (phase_nxt != PH_IDLE);
    res_o.done_res   = done;
    res_o.error_code = done ? err_r : ERR_NONE;
    res_o.read_value = value;
  end

  a_done_ends_busy: assert property (@(posedge clk) disable iff (!rst_n)
    res_o.done_res |-> !res_o.busy_res)
    else $error("done pulse while still busy");

  a_value_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    ((res_o.read_value != 16'h0000) || (res_o.error_code != ERR_NONE)) |-> res_o.done_res)
    else $error("result fields set without done");

  a_idle_no_countdown: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == PH_IDLE) |-> (tick_r == '0))
    else $error("tick counter running while idle");

  a_fin_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (step_i && (phase_r == PH_FIN) && (tick_r == '0)) |=> (phase_r == PH_IDLE))
    else $error("finish step did not return to idle");

endmodule

// File: rtl/core/sht_out_reg.sv
// result register holding one tick's line levels and status
module sht_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load_i,
  input  sht_pkg::seq_result_t res_i,
  output logic                 space_o,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output sht_pkg::seq_result_t res_o
);
  import sht_pkg::*;

  logic        valid_r, valid_nxt;
  seq_result_t res_r;

  assign space_o = !valid_r || out_ready_i;

  always_comb begin
    valid_nxt = valid_r;
    if (load_i) begin
      valid_nxt = 1'b1;
    end else if (out_ready_i) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_i) begin
      res_r <= res_i;
    end
  end

  assign out_valid_o = valid_r;
  assign res_o       = res_r;

endmodule
